// File: hw/rtl/dosc_pkg.sv
// ----------------------------------------------------------------------------
// dosc_pkg
// Shared widths, constants, command types and saturation helpers for the
// damped oscillator step block.
// ----------------------------------------------------------------------------
package dosc_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int TIME_W     = 16;
	localparam int ACC_W      = 24;
	localparam int CFG_W      = 24;
	localparam int HSL_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int STATE_W    = 32;
	localparam int FRAC_OUT_W = 18;
	localparam int OFF_W      = 12;

	// Shared multiplier: a coefficient-like operand times a state-like operand.
	localparam int A_W    = CFG_W + 1;
	localparam int B_W    = 36;
	localparam int SUM_W  = B_W;
	localparam int PROD_W = A_W + B_W;

	// Constant divider: a 52-bit magnitude taken as four 13-bit digits, each
	// digit of the quotient found by a reciprocal multiply and one correction.
	localparam int DIV_W       = 52;
	localparam int DIV_DIG_W   = 13;
	localparam int DIV_DIGITS  = DIV_W / DIV_DIG_W;
	localparam int DIV_CNT_W   = $clog2(DIV_DIGITS + 1);
	localparam int REM_W       = 10;
	localparam int DIV_T_W     = REM_W + DIV_DIG_W;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 18;
	localparam int DIV_EST_W   = DIV_T_W + RECIP_W;

	localparam logic [REM_W-1:0] DIVISOR_POS = REM_W'(100);
	localparam logic [REM_W-1:0] DIVISOR_VEL = REM_W'(600);
	localparam logic [RECIP_W-1:0] RECIP_POS = RECIP_W'((1 << RECIP_SHIFT) / 100);
	localparam logic [RECIP_W-1:0] RECIP_VEL = RECIP_W'((1 << RECIP_SHIFT) / 600);

	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SPRING  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_INV_RNG = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_SL = CFG_IDX_W'(3);

	localparam logic [HSL_W-1:0] HSL_RESET = HSL_W'(30);

	localparam logic signed [PROD_W-1:0] S32_HI =
		PROD_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
	localparam logic signed [PROD_W-1:0] S32_LO = -S32_HI - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] FRAC_HI =
		PROD_W'((64'sd1 <<< (FRAC_OUT_W - 1)) - 64'sd1);
	localparam logic signed [PROD_W-1:0] FRAC_LO = -FRAC_HI - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] OFF_HI =
		PROD_W'((64'sd1 <<< (OFF_W - 1)) - 64'sd1);
	localparam logic signed [PROD_W-1:0] OFF_LO = -OFF_HI - PROD_W'(1);

	typedef enum logic [2:0] {
		MUL_KX = 3'd0,
		MUL_CV = 3'd1,
		MUL_DV = 3'd2,
		MUL_DS = 3'd3,
		MUL_FR = 3'd4,
		MUL_OF = 3'd5
	} mul_sel_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		mul_sel_t   mul_sel;
		logic       base_ld;
		logic       slope_ld;
		logic       vstage_ld;
		logic       acc_en;
		logic [1:0] stage;
		logic       phase;
		logic       div_start;
		logic       upd;
		logic       frac_ld;
		logic       out_ld;
	} dosc_cmd_t;

	typedef struct packed {
		logic div_busy;
	} dosc_sts_t;

	function automatic logic signed [STATE_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [STATE_W-1:0] r;
		r = (v > S32_HI) ? S32_HI[STATE_W-1:0] :
		    (v < S32_LO) ? S32_LO[STATE_W-1:0] : v[STATE_W-1:0];
		return r;
	endfunction

	function automatic logic signed [FRAC_OUT_W-1:0] sat_frac(
		input logic signed [PROD_W-1:0] v);
		logic signed [FRAC_OUT_W-1:0] r;
		r = (v > FRAC_HI) ? FRAC_HI[FRAC_OUT_W-1:0] :
		    (v < FRAC_LO) ? FRAC_LO[FRAC_OUT_W-1:0] : v[FRAC_OUT_W-1:0];
		return r;
	endfunction

	function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [PROD_W-1:0] v);
		logic signed [OFF_W-1:0] r;
		r = (v > OFF_HI) ? OFF_HI[OFF_W-1:0] :
		    (v < OFF_LO) ? OFF_LO[OFF_W-1:0] : v[OFF_W-1:0];
		return r;
	endfunction

endpackage

// File: hw/rtl/dosc_div.sv
// ----------------------------------------------------------------------------
// dosc_div
// Unsigned divider by a constant of 100 or 600, forming one 13-bit quotient
// digit at a time by reciprocal multiplication: an estimate, then a correction.
// ----------------------------------------------------------------------------
module dosc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       sel_vel,
	input  logic [dosc_pkg::DIV_W-1:0] dividend,
	output logic                       busy,
	output logic [dosc_pkg::DIV_W-1:0] quotient
);
	import dosc_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 fix_q;
	logic [DIV_W-1:0]     quo_q;
	logic [REM_W-1:0]     rem_q, rem_nx;
	logic [REM_W-1:0]     dvs_q;
	logic [RECIP_W-1:0]   rcp_q;
	logic [DIV_DIG_W-1:0] qe_q, qd_nx;
	logic [DIV_T_W-1:0]   t_w, back_w, r_w;
	logic [DIV_EST_W-1:0] est_w;

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

	// The partial remainder stays below the divisor, so each quotient digit is
	// under 2^13 and the truncated reciprocal estimate is low by at most one.
	assign t_w    = {rem_q, quo_q[DIV_W-1 -: DIV_DIG_W]};
	assign est_w  = DIV_EST_W'(t_w) * DIV_EST_W'(rcp_q);
	assign back_w = DIV_T_W'(qe_q) * DIV_T_W'(dvs_q);
	assign r_w    = t_w - back_w;

	always_comb begin
		if (r_w >= DIV_T_W'(dvs_q)) begin
			qd_nx  = qe_q + DIV_DIG_W'(1);
			rem_nx = REM_W'(r_w - DIV_T_W'(dvs_q));
		end else begin
			qd_nx  = qe_q;
			rem_nx = r_w[REM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fix_q <= 1'b0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_DIGITS);
			fix_q <= 1'b0;
		end else if (busy) begin
			fix_q <= !fix_q;
			if (fix_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= sel_vel ? DIVISOR_VEL : DIVISOR_POS;
			rcp_q <= sel_vel ? RECIP_VEL : RECIP_POS;
		end else if (busy) begin
			if (fix_q) begin
				quo_q <= {quo_q[DIV_W-DIV_DIG_W-1:0], qd_nx};
				rem_q <= rem_nx;
			end else begin
				qe_q <= est_w[RECIP_SHIFT +: DIV_DIG_W];
			end
		end
	end

endmodule

// File: hw/rtl/dosc_dpath.sv
// ----------------------------------------------------------------------------
// dosc_dpath
// Datapath: configuration registers, oscillator state, one shared registered
// multiplier, slope and stage arithmetic, constant divider and result words.
// ----------------------------------------------------------------------------
module dosc_dpath #(
	parameter int FRAC_BITS = dosc_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic [dosc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dosc_pkg::CFG_W-1:0]             cfg_data,
	input  logic [dosc_pkg::TIME_W-1:0]            now_ms,
	input  logic signed [dosc_pkg::ACC_W-1:0]      ext_accel,
	input  logic                                   restart,
	input  dosc_pkg::dosc_cmd_t                    cmd,
	output dosc_pkg::dosc_sts_t                    sts,
	output logic signed [dosc_pkg::FRAC_OUT_W-1:0] position_fraction,
	output logic signed [dosc_pkg::OFF_W-1:0]      strand_offset
);
	import dosc_pkg::*;

	localparam logic [CFG_W-1:0] ONE_FX = CFG_W'(1 << FRAC_BITS);
	localparam logic signed [PROD_W-1:0] TRUNC_ADJ = PROD_W'((1 << FRAC_BITS) - 1);

	logic [CFG_W-1:0] damping_q, spring_q, inv_range_q;
	logic [HSL_W-1:0] half_len_q;

	logic signed [STATE_W-1:0] x_q, v_q;
	logic [TIME_W-1:0]         last_time_q;

	logic [TIME_W-1:0]          d_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [PROD_W-1:0]   prod_q, base_q;
	logic signed [STATE_W-1:0]  k_q, vs_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [FRAC_OUT_W-1:0] frac_q, pos_frac_q;
	logic signed [OFF_W-1:0]    off_q;
	logic                       div_neg_q;

	logic signed [A_W-1:0]    mul_a;
	logic signed [B_W-1:0]    mul_b;
	logic signed [PROD_W-1:0] prod_w, prod_sh, prod_abs, quo_s, off_t, vs_sum, upd_sum;
	logic signed [STATE_W-1:0] slope_w;
	logic signed [SUM_W-1:0]  k_term;
	logic                     div_busy;
	logic [DIV_W-1:0]         quotient;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_KX: begin
				mul_a = signed'({1'b0, spring_q});
				mul_b = B_W'(x_q);
			end
			MUL_CV: begin
				mul_a = signed'({1'b0, damping_q});
				mul_b = B_W'(vs_q);
			end
			MUL_DV: begin
				mul_a = signed'({{(A_W-TIME_W){1'b0}}, d_q});
				mul_b = B_W'(v_q);
			end
			MUL_DS: begin
				mul_a = signed'({{(A_W-TIME_W){1'b0}}, d_q});
				mul_b = sum_q;
			end
			MUL_FR: begin
				mul_a = signed'({1'b0, inv_range_q});
				mul_b = B_W'(x_q);
			end
			MUL_OF: begin
				mul_a = signed'({{(A_W-HSL_W){1'b0}}, half_len_q});
				mul_b = B_W'(frac_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_w  = mul_a * mul_b;
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign slope_w = sat32(base_q - prod_sh);

	// k2 and k3 count twice in the weighted slope sum.
	assign k_term = (cmd.stage == 2'd1 || cmd.stage == 2'd2) ?
		(SUM_W'(k_q) <<< 1) : SUM_W'(k_q);

	assign vs_sum = PROD_W'(v_q) +
		((cmd.stage == 2'd2) ? PROD_W'(k_q) : PROD_W'(k_q >>> 1));

	assign prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign quo_s    = div_neg_q ? -PROD_W'(quotient) : PROD_W'(quotient);
	assign upd_sum  = (cmd.phase ? PROD_W'(v_q) : PROD_W'(x_q)) + quo_s;

	// Offset division rounds toward zero.
	assign off_t = prod_q[PROD_W-1] ? ((prod_q + TRUNC_ADJ) >>> FRAC_BITS) : prod_sh;

	dosc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.sel_vel  (cmd.phase),
		.dividend (prod_abs[DIV_W-1:0]),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign sts.div_busy = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damping_q   <= ONE_FX;
			spring_q    <= ONE_FX;
			inv_range_q <= ONE_FX;
			half_len_q  <= HSL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DAMPING: damping_q   <= cfg_data;
				CFG_SPRING:  spring_q    <= cfg_data;
				CFG_INV_RNG: inv_range_q <= cfg_data;
				CFG_HALF_SL: half_len_q  <= cfg_data[HSL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			v_q         <= '0;
			last_time_q <= '0;
		end else begin
			if (cmd.load) begin
				last_time_q <= now_ms;
				if (restart) begin
					x_q <= '0;
					v_q <= '0;
				end
			end
			if (cmd.upd) begin
				if (cmd.phase) begin
					v_q <= sat32(upd_sum);
				end else begin
					x_q <= sat32(upd_sum);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q   <= now_ms - last_time_q;
			acc_q <= ext_accel;
			vs_q  <= v_q;
			sum_q <= '0;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_w;
		end
		if (cmd.base_ld) begin
			base_q <= PROD_W'(acc_q) - prod_sh;
		end
		if (cmd.slope_ld) begin
			k_q <= slope_w;
		end
		if (cmd.acc_en) begin
			sum_q <= sum_q + k_term;
		end
		if (cmd.vstage_ld) begin
			vs_q <= sat32(vs_sum);
		end
		if (cmd.div_start) begin
			div_neg_q <= prod_q[PROD_W-1];
		end
		if (cmd.frac_ld) begin
			frac_q <= sat_frac(prod_sh);
		end
		if (cmd.out_ld) begin
			pos_frac_q <= frac_q;
			off_q      <= sat_off(off_t);
		end
	end

	assign position_fraction = pos_frac_q;
	assign strand_offset     = off_q;

endmodule

// File: hw/rtl/dosc_ctrl.sv
// ----------------------------------------------------------------------------
// dosc_ctrl
// Controller: sequences the shared multiplier, the four slope stages, the two
// constant divisions and the result word, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module dosc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                restart,
	output logic                out_valid,
	input  logic                out_ready,
	output dosc_pkg::dosc_cmd_t cmd,
	input  dosc_pkg::dosc_sts_t sts
);
	import dosc_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE     = 14'b00000000000001,
		ST_MUL_KX   = 14'b00000000000010,
		ST_BASE     = 14'b00000000000100,
		ST_SLOPE    = 14'b00000000001000,
		ST_VSTAGE   = 14'b00000000010000,
		ST_MUL_CV   = 14'b00000000100000,
		ST_MUL_D    = 14'b00000001000000,
		ST_DIV_GO   = 14'b00000010000000,
		ST_DIV_WAIT = 14'b00000100000000,
		ST_UPD      = 14'b00001000000000,
		ST_MUL_FR   = 14'b00010000000000,
		ST_FRAC     = 14'b00100000000000,
		ST_MUL_OF   = 14'b01000000000000,
		ST_OUT      = 14'b10000000000000
	} ctrl_state_t;

	ctrl_state_t state_q, state_nx;
	logic [1:0]  stage_q;
	logic        phase_q;
	logic        out_valid_q;
	logic        out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_nx      = state_q;
		cmd           = '0;
		cmd.mul_sel   = MUL_KX;
		cmd.stage     = stage_q;
		cmd.phase     = phase_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = restart ? ST_MUL_FR : ST_MUL_KX;
				end
			end
			ST_MUL_KX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_KX;
				state_nx    = ST_BASE;
			end
			ST_BASE: begin
				cmd.base_ld = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CV;
				state_nx    = ST_SLOPE;
			end
			ST_SLOPE: begin
				cmd.slope_ld = 1'b1;
				state_nx     = (stage_q == 2'd3) ? ST_MUL_D : ST_VSTAGE;
			end
			ST_VSTAGE: begin
				cmd.vstage_ld = 1'b1;
				cmd.acc_en    = 1'b1;
				state_nx      = ST_MUL_CV;
			end
			ST_MUL_CV: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CV;
				state_nx    = ST_SLOPE;
			end
			ST_MUL_D: begin
				// The last slope joins the sum while the position product is formed.
				cmd.acc_en  = !phase_q;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = phase_q ? MUL_DS : MUL_DV;
				state_nx    = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_nx      = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!sts.div_busy) begin
					state_nx = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd  = 1'b1;
				state_nx = phase_q ? ST_MUL_FR : ST_MUL_D;
			end
			ST_MUL_FR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FR;
				state_nx    = ST_FRAC;
			end
			ST_FRAC: begin
				cmd.frac_ld = 1'b1;
				state_nx    = ST_MUL_OF;
			end
			ST_MUL_OF: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_OF;
				state_nx    = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stage_q     <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load) begin
				stage_q <= '0;
				phase_q <= 1'b0;
			end else begin
				if (cmd.vstage_ld) begin
					stage_q <= stage_q + 2'd1;
				end
				if (cmd.upd) begin
					phase_q <= 1'b1;
				end
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_restart_skips_rk4: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && restart) |=> (state_q == ST_MUL_FR))
		else $error("restart word did not go straight to the output scaling");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while still busy");

	a_four_slopes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SLOPE && stage_q != 2'd3) |=> (state_q == ST_VSTAGE))
		else $error("slope sequence left before the fourth stage");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.out_ld)
		else $error("result word overwritten before it was taken");

endmodule

// File: hw/rtl/damped_oscillator_rk4_step.sv
// ----------------------------------------------------------------------------
// damped_oscillator_rk4_step
// Damped oscillator step: RK4 velocity update, Euler position update, and
// position scaled to a range fraction and a strand offset.
//
//   channel  signals                                    direction
//   input    in_valid/in_ready, now_ms, ext_accel,      in
//            restart
//   output   out_valid/out_ready, position_fraction,    out
//            strand_offset
//   config   cfg_valid/cfg_ready, cfg_index, cfg_data   in
//
// A regular word runs the four RK4 slope stages and two passes through the
// constant divider before the next word is accepted; a restart word goes
// straight to the output scaling. The single shared multiplier is used
// for every product in turn. Reset sets state to zero and the registers to
// their defaults at once. A new word is taken only while the sequencer is
// idle; a finished word stalls the sequencer only while the previous result
// word is still held on the output.
// ----------------------------------------------------------------------------
module damped_oscillator_rk4_step #(
	parameter int FRAC_BITS = dosc_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [dosc_pkg::TIME_W-1:0]            now_ms,
	input  logic signed [dosc_pkg::ACC_W-1:0]      ext_accel,
	input  logic                                   restart,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [dosc_pkg::FRAC_OUT_W-1:0] position_fraction,
	output logic signed [dosc_pkg::OFF_W-1:0]      strand_offset,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [dosc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dosc_pkg::CFG_W-1:0]             cfg_data
);
	import dosc_pkg::*;

	dosc_cmd_t cmd;
	dosc_sts_t sts;

	assign cfg_ready = 1'b1;

	dosc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dosc_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.now_ms            (now_ms),
		.ext_accel         (ext_accel),
		.restart           (restart),
		.cmd               (cmd),
		.sts               (sts),
		.position_fraction (position_fraction),
		.strand_offset     (strand_offset)
	);

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the damped oscillator step block. Each accepted
// input word is run through a local fixed-point model of the RK4 velocity
// step, the Euler position step and the output scaling. The predicted result
// words are queued and compared field by field with the words the block
// returns. Both handshakes stall at random. Coefficient registers change only
// while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
	import dosc_pkg::*;

	localparam int     CLK_PERIOD    = 12;
	localparam int     RESET_CYCLES  = 5;
	localparam int     IDLE_PCT      = 12;
	localparam int     SETTLE_CYCLES = 8;
	localparam longint RUN_LIMIT_NS  = 5_000_000;

	localparam longint LIM32_HI  = 64'sd2147483647;
	localparam longint LIM32_LO  = -64'sd2147483648;
	localparam longint FRAC_MAX  = 64'sd131071;
	localparam longint FRAC_MIN  = -64'sd131072;
	localparam longint OFS_MAX   = 64'sd2047;
	localparam longint OFS_MIN   = -64'sd2048;
	localparam longint FRAC_ONE  = longint'(1) << FRAC_BITS_DEF;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [CFG_W-1:0] COEF_MAX = {CFG_W{1'b1}};
	localparam logic [CFG_W-1:0] COEF_ONE = CFG_W'(1) << FRAC_BITS_DEF;
	localparam logic [HSL_W-1:0] HSL_MAX  = {HSL_W{1'b1}};

	typedef struct packed {
		logic signed [FRAC_OUT_W-1:0] frac;
		logic signed [OFF_W-1:0]      offset;
	} scaled_pos_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [TIME_W-1:0]             now_ms = '0;
	logic signed [ACC_W-1:0]       ext_accel = '0;
	logic                          restart = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [FRAC_OUT_W-1:0]  position_fraction;
	logic signed [OFF_W-1:0]       strand_offset;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]              cfg_data = '0;

	// Local copy of the coefficient registers and the motion state.
	logic [CFG_W-1:0]  damp_c    = COEF_ONE;
	logic [CFG_W-1:0]  spring_k  = COEF_ONE;
	logic [CFG_W-1:0]  inv_range = COEF_ONE;
	logic [HSL_W-1:0]  half_len  = HSL_RESET;
	longint            osc_pos   = 0;
	longint            osc_vel   = 0;
	logic [TIME_W-1:0] osc_last  = '0;

	scaled_pos_t       pending_positions[$];
	int                err_count = 0;
	logic              steady = 1'b0;
	logic [TIME_W-1:0] clock_ms = '0;

	damped_oscillator_rk4_step u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.now_ms            (now_ms),
		.ext_accel         (ext_accel),
		.restart           (restart),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.position_fraction (position_fraction),
		.strand_offset     (strand_offset),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	function automatic longint bound(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint clip(input longint v);
		return bound(v, LIM32_LO, LIM32_HI);
	endfunction

	// Acceleration -c*v - k*x + a_ext with floor-rounded products.
	function automatic longint accel_at(input longint v, input longint x, input longint a_ext);
		longint cv;
		longint kx;
		cv = (longint'(damp_c) * v) >>> FRAC_BITS_DEF;
		kx = (longint'(spring_k) * x) >>> FRAC_BITS_DEF;
		return clip(a_ext - cv - kx);
	endfunction

	task automatic advance_oscillator(input logic [TIME_W-1:0] t,
			input logic signed [ACC_W-1:0] a, input logic rs, output scaled_pos_t res);
		logic [TIME_W-1:0] dt_ms;
		longint acc, d, k1, k2, k3, k4, s, new_vel, fr, ofs;
		acc = longint'(a);
		if (rs) begin
			osc_pos = 0;
			osc_vel = 0;
		end else begin
			dt_ms = t - osc_last;
			d = longint'(dt_ms);
			k1 = accel_at(osc_vel, osc_pos, acc);
			k2 = accel_at(clip(osc_vel + (k1 >>> 1)), osc_pos, acc);
			k3 = accel_at(clip(osc_vel + (k2 >>> 1)), osc_pos, acc);
			k4 = accel_at(clip(osc_vel + k3), osc_pos, acc);
			s = k1 + 2 * k2 + 2 * k3 + k4;
			new_vel = clip(osc_vel + (d * s) / 600);
			// Position moves with the velocity from before this step.
			osc_pos = clip(osc_pos + (d * osc_vel) / 100);
			osc_vel = new_vel;
		end
		osc_last = t;
		fr = bound((osc_pos * longint'(inv_range)) >>> FRAC_BITS_DEF, FRAC_MIN, FRAC_MAX);
		ofs = bound((fr * longint'(half_len)) / FRAC_ONE, OFS_MIN, OFS_MAX);
		res.frac = fr[FRAC_OUT_W-1:0];
		res.offset = ofs[OFF_W-1:0];
	endtask

	task automatic send_word(input logic [TIME_W-1:0] t, input logic signed [ACC_W-1:0] a,
			input logic rs);
		scaled_pos_t res;
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t;
		ext_accel <= a;
		restart <= rs;
		do @(posedge clk); while (!in_ready);
		advance_oscillator(t, a, rs, res);
		pending_positions.push_back(res);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (pending_positions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_DAMPING: damp_c = data;
			CFG_SPRING:  spring_k = data;
			CFG_INV_RNG: inv_range = data;
			CFG_HALF_SL: half_len = data[HSL_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] k,
			input logic [CFG_W-1:0] r, input logic [HSL_W-1:0] h);
		wait_for_drain();
		write_reg(CFG_DAMPING, c);
		write_reg(CFG_SPRING, k);
		write_reg(CFG_INV_RNG, r);
		write_reg(CFG_HALF_SL, CFG_W'(h));
	endtask

	function automatic logic signed [ACC_W-1:0] rand_accel();
		if ($urandom_range(99) < 20)
			return ACC_W'($urandom);
		return ACC_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
	endfunction

	function automatic logic [TIME_W-1:0] rand_dt();
		case ($urandom_range(19))
			0: return '0;
			1: return TIME_W'($urandom);
			default: return TIME_W'($urandom_range(1, 60));
		endcase
	endfunction

	// A restart followed by a run of ordinary steps with advancing time.
	task automatic run_motion(input int steps);
		clock_ms = TIME_W'($urandom);
		send_word(clock_ms, rand_accel(), 1'b1);
		repeat (steps) begin
			clock_ms = clock_ms + rand_dt();
			send_word(clock_ms, rand_accel(), 1'b0);
		end
	endtask

	task automatic test_directed();
		send_word(16'd100, 24'sd0, 1'b1);
		send_word(16'd100, ACC_MAX, 1'b0);
		send_word(16'd200, ACC_MAX, 1'b0);
		send_word(16'd300, -24'sd1, 1'b0);
		send_word(16'd65535, ACC_MAX, 1'b0);
		// Time wraps past zero here.
		send_word(16'd10, ACC_MIN, 1'b0);
		send_word(16'd10, ACC_MIN, 1'b0);
		send_word(16'd9, ACC_MIN, 1'b0);
		send_word(16'd8, ACC_MAX, 1'b0);
		send_word(16'd65535, ACC_MIN, 1'b1);
		send_word(16'd0, ACC_MAX, 1'b0);
		send_word(16'd0, 24'sd0, 1'b1);
		send_word(16'd65535, ACC_MAX, 1'b0);
		send_word(16'd65534, ACC_MAX, 1'b0);
		send_word(16'd65533, ACC_MAX, 1'b0);
		send_word(16'd65532, ACC_MIN, 1'b0);
		send_word(16'd65531, ACC_MIN, 1'b0);
		send_word(16'd65530, ACC_MIN, 1'b0);
		send_word(16'd65535, 24'sh555555, 1'b0);
		send_word(16'd65535, 24'shAAAAAA, 1'b0);
		send_word(16'hAAAA, 24'sd65536, 1'b1);
		send_word(16'hAAB4, 24'sd65536, 1'b0);
		send_word(16'hAABE, 24'sd0, 1'b0);
		send_word(16'h5555, -24'sd65536, 1'b0);
	endtask

	task automatic test_coefficient_extremes();
		load_settings('0, '0, COEF_MAX, HSL_MAX);
		run_motion(24);
		load_settings(COEF_MAX, COEF_MAX, '0, '0);
		run_motion(24);
		load_settings(COEF_MAX, '0, COEF_MAX, HSL_MAX);
		run_motion(24);
		load_settings(CFG_W'(1), COEF_MAX, CFG_W'(1), HSL_W'(1));
		run_motion(24);
		load_settings(COEF_ONE, COEF_ONE, COEF_ONE, HSL_RESET);
		run_motion(24);
	endtask

	task automatic test_random_motion();
		logic [CFG_W-1:0] c, k, r;
		// First stretch runs with no idling on either side.
		steady = 1'b1;
		repeat (6) run_motion($urandom_range(15, 35));
		steady = 1'b0;
		repeat (20) begin
			if ($urandom_range(3) == 0) begin
				c = ($urandom_range(9) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 4 << 16));
				k = ($urandom_range(9) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 4 << 16));
				r = ($urandom_range(9) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 2 << 16));
				load_settings(c, k, r, HSL_W'($urandom_range(0, 1023)));
			end
			run_motion($urandom_range(5, 35));
			// Occasional noise: arbitrary time, acceleration and restart.
			repeat ($urandom_range(0, 4))
				send_word(TIME_W'($urandom), ACC_W'($urandom), 1'($urandom_range(1)));
		end
	endtask

	task automatic test_sender_pause();
		run_motion(20);
		wait_for_drain();
		repeat (20) begin
			clock_ms = clock_ms + rand_dt();
			send_word(clock_ms, rand_accel(), 1'b0);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_coefficient_extremes();
		test_random_motion();
		test_sender_pause();
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : check_results
		scaled_pos_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_positions.size() == 0) begin
				err_count++;
				$display("%0t unexpected result word: frac=%0d offset=%0d",
					$time, position_fraction, strand_offset);
			end else begin
				want = pending_positions.pop_front();
				if (position_fraction !== want.frac) begin
					err_count++;
					$display("%0t position_fraction mismatch: expected %0d, actual %0d",
						$time, want.frac, position_fraction);
				end
				if (strand_offset !== want.offset) begin
					err_count++;
					$display("%0t strand_offset mismatch: expected %0d, actual %0d",
						$time, want.offset, strand_offset);
				end
			end
		end
	end

endmodule

// File: files.f
hw/rtl/dosc_pkg.sv
hw/rtl/dosc_div.sv
hw/rtl/dosc_dpath.sv
hw/rtl/dosc_ctrl.sv
hw/rtl/damped_oscillator_rk4_step.sv
verif/tb_top.sv
